FILE: sv/pad_and_memory_card_responder_top_assert.svh
// Assertion helpers for the RTL (used by pmcr_dp); expect clk and rst_n in scope.
`ifndef PAD_AND_MEMORY_CARD_RESPONDER_TOP_ASSERT_SVH
`define PAD_AND_MEMORY_CARD_RESPONDER_TOP_ASSERT_SVH

// same-cycle implication
`define PMCR_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define PMCR_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/pmcr_pkg.sv
package pmcr_pkg;

    localparam int unsigned SECTOR_BYTES = 128;

    localparam logic [1:0] DEV_NONE = 2'd0;
    localparam logic [1:0] DEV_PAD  = 2'd1;
    localparam logic [1:0] DEV_CARD = 2'd2;

    localparam logic [7:0] STEP_DONE    = 8'hFF;
    localparam logic [7:0] BYTE_IDLE    = 8'hFF;
    localparam logic [7:0] CMD_SELECT   = 8'h81;
    localparam logic [7:0] CMD_PAD_POLL = 8'h01;
    localparam logic [7:0] PAD_ID       = 8'h41;
    localparam logic [7:0] BYTE_5A      = 8'h5A;
    localparam logic [7:0] BYTE_5D      = 8'h5D;
    localparam logic [7:0] BYTE_5C      = 8'h5C;
    localparam logic [7:0] END_GOOD     = 8'h47;
    localparam logic [7:0] END_BAD      = 8'h4E;
    localparam logic [7:0] CARD_READ    = 8'h52;
    localparam logic [7:0] CARD_WRITE   = 8'h57;
    localparam logic [7:0] CARD_GET_ID  = 8'h53;
    localparam logic [7:0] FLAG_RESET   = 8'h08;

    localparam logic [0:0] REG_PAD_CONNECTED = 1'd0;
    localparam logic [0:0] REG_CARD_PRESENT  = 1'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_STEP,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic latch;
        logic rd;
        logic step;
        logic clear;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_full;
        logic commit_req;
        logic clear_last;
        logic commit_last;
    } dp_status_t;

    function automatic logic [7:0] id_reply(input logic [2:0] pos);
        logic [7:0] r;
        unique case (pos)
            3'd0:    r = 8'h5C;
            3'd1:    r = 8'h5D;
            3'd2:    r = 8'h04;
            3'd3:    r = 8'h00;
            3'd4:    r = 8'h00;
            3'd5:    r = 8'h80;
            default: r = 8'hFF;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/pmcr_ctrl.sv
module pmcr_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pmcr_pkg::dp_status_t status,
    output pmcr_pkg::dp_cmd_t    cmd
);

    pmcr_pkg::state_t state_reg;
    pmcr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pmcr_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            pmcr_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = pmcr_pkg::ST_IDLE;
                end
            end
            pmcr_pkg::ST_IDLE:
            begin
                s_tready = !status.out_full;
                if (s_tvalid && !status.out_full)
                begin
                    cmd.latch  = 1'b1;
                    state_next = pmcr_pkg::ST_READ;
                end
            end
            pmcr_pkg::ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = pmcr_pkg::ST_STEP;
            end
            pmcr_pkg::ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = status.commit_req ? pmcr_pkg::ST_COMMIT : pmcr_pkg::ST_IDLE;
            end
            pmcr_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                if (status.commit_last)
                begin
                    state_next = pmcr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pmcr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/pmcr_dp.sv
`include "pad_and_memory_card_responder_top_assert.svh"

module pmcr_dp
#(
    parameter int unsigned SECTOR_COUNT = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pmcr_pkg::dp_cmd_t    cmd,
    output pmcr_pkg::dp_status_t status,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [0:0]           cfg_data,
    input  logic                 in_op,
    input  logic [7:0]           in_tx_byte,
    input  logic [15:0]          in_buttons,
    output logic                 out_valid,
    input  logic                 out_taken,
    output logic [7:0]           out_rx_byte,
    output logic                 out_ack
);

    localparam int unsigned SW    = $clog2(SECTOR_COUNT);
    localparam int unsigned AW    = SW + 7;
    localparam int unsigned DEPTH = SECTOR_COUNT * pmcr_pkg::SECTOR_BYTES;

    logic [7:0] store_mem [DEPTH];
    logic [7:0] wbuf_mem [pmcr_pkg::SECTOR_BYTES];
    logic [7:0] store_q;
    logic [7:0] wbuf_q;

    logic        pad_connected_reg;
    logic        card_present_reg;
    logic        op_reg;
    logic [7:0]  tx_reg;
    logic [15:0] buttons_reg;
    logic [1:0]  dev_reg, dev_next;
    logic [2:0]  pad_step_reg, pad_step_next;
    logic [7:0]  card_step_reg, card_step_next;
    logic [7:0]  card_cmd_reg, card_cmd_next;
    logic [15:0] sector_reg, sector_next;
    logic [7:0]  csum_reg, csum_next;
    logic [7:0]  prev_reg, prev_next;
    logic [7:0]  flag_reg, flag_next;
    logic        wgood_reg, wgood_next;
    logic [AW-1:0] cnt_reg;
    logic        out_valid_reg;
    logic [7:0]  rx_reg, rx_next;
    logic        ack_reg, ack_next;
    logic        commit_req;
    logic        wbuf_we;
    logic [6:0]  wbuf_waddr;
    logic        in_range;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign in_range = sector_reg < 16'(SECTOR_COUNT);
    assign rd_addr  = {sector_reg[SW-1:0], 7'(card_step_reg - 8'd9)};
    assign wr_addr  = {sector_reg[SW-1:0], 7'(cnt_reg - AW'(1))};

    always_comb
    begin
        logic       do_pad;
        logic [7:0] pos;
        dev_next       = dev_reg;
        pad_step_next  = pad_step_reg;
        card_step_next = card_step_reg;
        card_cmd_next  = card_cmd_reg;
        sector_next    = sector_reg;
        csum_next      = csum_reg;
        prev_next      = prev_reg;
        flag_next      = flag_reg;
        wgood_next     = wgood_reg;
        rx_next        = pmcr_pkg::BYTE_IDLE;
        ack_next       = 1'b0;
        commit_req     = 1'b0;
        wbuf_we        = 1'b0;
        wbuf_waddr     = 7'(card_step_reg - 8'd5);
        do_pad         = 1'b0;
        pos            = card_step_reg - 8'd5;

        if (op_reg)
        begin
            dev_next       = pmcr_pkg::DEV_NONE;
            card_step_next = 8'd0;
            pad_step_next  = 3'd0;
        end
        else if (dev_reg == pmcr_pkg::DEV_PAD)
        begin
            do_pad = 1'b1;
        end
        else if (dev_reg == pmcr_pkg::DEV_CARD)
        begin
            unique case (card_step_reg)
                8'd0:
                begin
                    card_cmd_next  = tx_reg;
                    csum_next      = 8'd0;
                    card_step_next = 8'd1;
                    rx_next        = flag_reg;
                end
                8'd1:
                begin
                    card_step_next = 8'd2;
                    rx_next        = pmcr_pkg::BYTE_5A;
                end
                8'd2:
                begin
                    card_step_next = 8'd3;
                    rx_next        = pmcr_pkg::BYTE_5D;
                end
                8'd3:
                begin
                    sector_next    = {tx_reg, 8'd0};
                    csum_next      = tx_reg;
                    prev_next      = tx_reg;
                    card_step_next = 8'd4;
                    rx_next        = 8'd0;
                end
                8'd4:
                begin
                    sector_next    = {sector_reg[15:8], tx_reg};
                    csum_next      = csum_reg ^ tx_reg;
                    rx_next        = prev_reg;
                    prev_next      = tx_reg;
                    card_step_next = 8'd5;
                end
                default:
                begin
                    if (card_step_reg == pmcr_pkg::STEP_DONE)
                    begin
                        rx_next = pmcr_pkg::BYTE_IDLE;
                    end
                    else if (card_cmd_reg == pmcr_pkg::CARD_READ)
                    begin
                        card_step_next = card_step_reg + 8'd1;
                        if (pos == 8'd0)
                        begin
                            rx_next = pmcr_pkg::BYTE_5C;
                        end
                        else if (pos == 8'd1)
                        begin
                            rx_next = pmcr_pkg::BYTE_5D;
                        end
                        else if (pos == 8'd2)
                        begin
                            rx_next   = sector_reg[15:8];
                            csum_next = sector_reg[15:8];
                        end
                        else if (pos == 8'd3)
                        begin
                            rx_next   = sector_reg[7:0];
                            csum_next = csum_reg ^ sector_reg[7:0];
                        end
                        else if (pos < 8'd132)
                        begin
                            rx_next   = in_range ? store_q : pmcr_pkg::BYTE_IDLE;
                            csum_next = csum_reg ^ rx_next;
                        end
                        else if (pos == 8'd132)
                        begin
                            rx_next = csum_reg;
                        end
                        else if (pos == 8'd133)
                        begin
                            card_step_next = pmcr_pkg::STEP_DONE;
                            rx_next        = pmcr_pkg::END_GOOD;
                        end
                        else
                        begin
                            card_step_next = card_step_reg;
                        end
                    end
                    else if (card_cmd_reg == pmcr_pkg::CARD_WRITE)
                    begin
                        card_step_next = card_step_reg + 8'd1;
                        if (pos < 8'd128)
                        begin
                            rx_next   = prev_reg;
                            wbuf_we   = 1'b1;
                            csum_next = csum_reg ^ tx_reg;
                            prev_next = tx_reg;
                        end
                        else if (pos == 8'd128)
                        begin
                            rx_next    = prev_reg;
                            wgood_next = (tx_reg == csum_reg) && in_range;
                            if (wgood_next)
                            begin
                                commit_req = 1'b1;
                                flag_next  = flag_reg & ~pmcr_pkg::FLAG_RESET;
                            end
                        end
                        else if (pos == 8'd129)
                        begin
                            rx_next = pmcr_pkg::BYTE_5C;
                        end
                        else if (pos == 8'd130)
                        begin
                            rx_next = pmcr_pkg::BYTE_5D;
                        end
                        else if (pos == 8'd131)
                        begin
                            card_step_next = pmcr_pkg::STEP_DONE;
                            rx_next = wgood_reg ? pmcr_pkg::END_GOOD : pmcr_pkg::END_BAD;
                        end
                        else
                        begin
                            card_step_next = card_step_reg;
                        end
                    end
                    else if (card_cmd_reg == pmcr_pkg::CARD_GET_ID && pos < 8'd6)
                    begin
                        card_step_next = (pos == 8'd5) ? pmcr_pkg::STEP_DONE
                                                       : card_step_reg + 8'd1;
                        rx_next        = pmcr_pkg::id_reply(pos[2:0]);
                    end
                end
            endcase
            ack_next = card_step_next != pmcr_pkg::STEP_DONE;
        end
        else if (tx_reg == pmcr_pkg::CMD_SELECT && card_present_reg)
        begin
            dev_next       = pmcr_pkg::DEV_CARD;
            card_step_next = 8'd0;
            ack_next       = 1'b1;
        end
        else if (pad_connected_reg)
        begin
            do_pad = 1'b1;
        end

        if (do_pad)
        begin
            unique case (pad_step_reg)
                3'd0:
                begin
                    if (tx_reg == pmcr_pkg::CMD_PAD_POLL)
                    begin
                        pad_step_next = 3'd1;
                        rx_next       = pmcr_pkg::PAD_ID;
                    end
                end
                3'd1:
                begin
                    pad_step_next = 3'd2;
                    rx_next       = pmcr_pkg::BYTE_5A;
                end
                3'd2:
                begin
                    pad_step_next = 3'd3;
                    rx_next       = buttons_reg[15:8];
                end
                3'd3:
                begin
                    pad_step_next = 3'd4;
                    rx_next       = buttons_reg[7:0];
                end
                default:
                begin
                    pad_step_next = 3'd4;
                end
            endcase
            ack_next = pad_step_next != pad_step_reg;
            if (ack_next)
            begin
                dev_next = pmcr_pkg::DEV_PAD;
            end
        end

        if (!ack_next)
        begin
            dev_next = pmcr_pkg::DEV_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_connected_reg <= 1'b0;
            card_present_reg  <= 1'b0;
            dev_reg           <= pmcr_pkg::DEV_NONE;
            pad_step_reg      <= 3'd0;
            card_step_reg     <= 8'd0;
            card_cmd_reg      <= 8'd0;
            sector_reg        <= 16'd0;
            csum_reg          <= 8'd0;
            prev_reg          <= 8'd0;
            flag_reg          <= pmcr_pkg::FLAG_RESET;
            wgood_reg         <= 1'b0;
            cnt_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == pmcr_pkg::REG_PAD_CONNECTED)
            begin
                pad_connected_reg <= cfg_data[0];
            end
            if (cfg_we && cfg_index == pmcr_pkg::REG_CARD_PRESENT)
            begin
                card_present_reg <= cfg_data[0];
            end
            if (cmd.step)
            begin
                dev_reg       <= dev_next;
                pad_step_reg  <= pad_step_next;
                card_step_reg <= card_step_next;
                card_cmd_reg  <= card_cmd_next;
                sector_reg    <= sector_next;
                csum_reg      <= csum_next;
                prev_reg      <= prev_next;
                flag_reg      <= flag_next;
                wgood_reg     <= wgood_next;
            end
            // shared counter: clear sweep after reset, then copy index
            if (cmd.clear)
            begin
                cnt_reg <= status.clear_last ? '0 : cnt_reg + AW'(1);
            end
            else if (cmd.step)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.commit)
            begin
                cnt_reg <= cnt_reg + AW'(1);
            end
            if (cmd.step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg      <= in_op;
            tx_reg      <= in_tx_byte;
            buttons_reg <= in_buttons;
        end
        if (cmd.step)
        begin
            rx_reg  <= rx_next;
            ack_reg <= ack_next;
        end
    end

    // card store: one write port (clear / commit), one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            store_mem[cnt_reg] <= 8'd0;
        end
        else if (cmd.commit && cnt_reg != '0)
        begin
            store_mem[wr_addr] <= wbuf_q;
        end
        if (cmd.rd && in_range)
        begin
            store_q <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && wbuf_we)
        begin
            wbuf_mem[wbuf_waddr] <= tx_reg;
        end
        if (cmd.commit)
        begin
            wbuf_q <= wbuf_mem[cnt_reg[6:0]];
        end
    end

    assign status.out_full    = out_valid_reg;
    assign status.commit_req  = commit_req;
    assign status.clear_last  = cnt_reg == AW'(DEPTH - 1);
    assign status.commit_last = cnt_reg == AW'(pmcr_pkg::SECTOR_BYTES);

    assign out_valid   = out_valid_reg;
    assign out_rx_byte = rx_reg;
    assign out_ack     = ack_reg;

    `PMCR_ASSERT_NXT(a_commit_clears_flag, cmd.step && commit_req, !flag_reg[3])
    `PMCR_ASSERT_IMP(a_result_follows_step, $rose(out_valid_reg), $past(cmd.step))
    `PMCR_ASSERT_NXT(a_deselect_idle_reply, cmd.step && op_reg,
                     rx_reg == pmcr_pkg::BYTE_IDLE && !ack_reg && dev_reg == pmcr_pkg::DEV_NONE)

endmodule

FILE: sv/pad_and_memory_card_responder_top.sv
// Device side of a pad / memory card serial link. Each input transfer is one
// host byte exchange (tuser = 0) or a chip-select release (tuser = 1); each
// gives exactly one output transfer with the reply byte and the ACK flag.
// An accepted transfer is latched, then the card store is read, then the
// step runs and loads the result register that is offered on the output.
// One item is in flight at a time and the next transfer is taken only once
// the result register is free. A write whose checksum matches and whose
// sector is in range adds a copy of the 128-byte write buffer into the card
// store, one byte per cycle through the store's single write port. After
// reset the card store is zeroed by a sweep over all SECTOR_COUNT*128 bytes
// before the first transfer is taken; config writes are taken at any time.
module pad_and_memory_card_responder_top
#(
    parameter int unsigned SECTOR_COUNT = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    // config: index 0 pad_connected, index 1 card_present
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [0:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] tx_byte, [23:8] buttons
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] rx_byte, [8] ack, [15:9] zero
);

    pmcr_pkg::dp_cmd_t    cmd;
    pmcr_pkg::dp_status_t status;
    logic [7:0]           rx_byte;
    logic                 ack;

    pmcr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pmcr_dp
    #(
        .SECTOR_COUNT (SECTOR_COUNT)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_op       (s_tuser[0]),
        .in_tx_byte  (s_tdata[7:0]),
        .in_buttons  (s_tdata[23:8]),
        .out_valid   (m_tvalid),
        .out_taken   (m_tready),
        .out_rx_byte (rx_byte),
        .out_ack     (ack)
    );

    assign m_tdata = {7'd0, ack, rx_byte};

endmodule

FILE: test/tb_pad_and_memory_card_responder_top.sv
module tb_pad_and_memory_card_responder_top;

    localparam int unsigned NSECT = 1024;
    localparam int unsigned CARD_SIZE = NSECT * pmcr_pkg::SECTOR_BYTES;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic        op;
        logic [7:0]  tx;
        logic [15:0] buttons;
    } xfer_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       ack;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [0:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    pad_and_memory_card_responder_top #(.SECTOR_COUNT(NSECT)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata),     // [7:0] tx_byte, [23:8] buttons
        .s_tuser(s_tuser),     // [0] op
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata)      // [7:0] rx_byte, [8] ack
    );

    // ---------------- device shadow ----------------
    logic [7:0]  mem_img [CARD_SIZE];
    logic [7:0]  wbuf [pmcr_pkg::SECTOR_BYTES];
    logic [1:0]  sel_dev;
    logic [2:0]  pstep;
    logic [7:0]  cstep;
    logic [7:0]  ccmd;
    logic [15:0] sect;
    logic [7:0]  csum;
    logic [7:0]  last_tx;
    logic [7:0]  flag;
    logic        wr_ok;
    logic        pad_on;
    logic        card_on;

    xfer_t  pending[$];     // items waiting for the driver
    reply_t replies[$];     // replies expected from the block
    int     n_bad;
    longint cycles;

    function automatic logic [7:0] pad_reply(logic [7:0] tx, logic [15:0] b);
        case (pstep)
            3'd0:
            begin
                if (tx == pmcr_pkg::CMD_PAD_POLL)
                begin
                    pstep = 3'd1;
                    return pmcr_pkg::PAD_ID;
                end
                return pmcr_pkg::BYTE_IDLE;
            end
            3'd1: begin pstep = 3'd2; return pmcr_pkg::BYTE_5A; end
            3'd2: begin pstep = 3'd3; return b[15:8]; end
            3'd3: begin pstep = 3'd4; return b[7:0]; end
            default: begin pstep = 3'd4; return pmcr_pkg::BYTE_IDLE; end
        endcase
    endfunction

    function automatic logic [7:0] card_read_reply(int unsigned pos);
        logic [7:0] r;
        int unsigned off;
        r = pmcr_pkg::BYTE_IDLE;
        if (pos == 0) r = pmcr_pkg::BYTE_5C;
        else if (pos == 1) r = pmcr_pkg::BYTE_5D;
        else if (pos == 2) begin r = sect[15:8]; csum = r; end
        else if (pos == 3) begin r = sect[7:0]; csum ^= r; end
        else if (pos < 4 + pmcr_pkg::SECTOR_BYTES)
        begin
            off = int'(sect) * pmcr_pkg::SECTOR_BYTES + (pos - 4);
            r = (off < CARD_SIZE) ? mem_img[off] : 8'hFF;
            csum ^= r;
        end
        else if (pos == 4 + pmcr_pkg::SECTOR_BYTES) r = csum;
        else if (pos == 5 + pmcr_pkg::SECTOR_BYTES)
        begin
            cstep = pmcr_pkg::STEP_DONE;
            return pmcr_pkg::END_GOOD;
        end
        else return pmcr_pkg::BYTE_IDLE;
        cstep++;
        return r;
    endfunction

    function automatic logic [7:0] card_write_reply(int unsigned pos, logic [7:0] tx);
        logic [7:0] r;
        r = pmcr_pkg::BYTE_IDLE;
        if (pos < pmcr_pkg::SECTOR_BYTES)
        begin
            r = last_tx;
            wbuf[pos] = tx;
            csum ^= tx;
            last_tx = tx;
        end
        else if (pos == pmcr_pkg::SECTOR_BYTES)
        begin
            r = last_tx;
            wr_ok = (tx == csum) && (sect < NSECT);
            if (wr_ok)
            begin
                for (int i = 0; i < pmcr_pkg::SECTOR_BYTES; i++)
                    mem_img[int'(sect) * pmcr_pkg::SECTOR_BYTES + i] = wbuf[i];
                flag &= ~pmcr_pkg::FLAG_RESET;
            end
        end
        else if (pos == pmcr_pkg::SECTOR_BYTES + 1) r = pmcr_pkg::BYTE_5C;
        else if (pos == pmcr_pkg::SECTOR_BYTES + 2) r = pmcr_pkg::BYTE_5D;
        else if (pos == pmcr_pkg::SECTOR_BYTES + 3)
        begin
            cstep = pmcr_pkg::STEP_DONE;
            return wr_ok ? pmcr_pkg::END_GOOD : pmcr_pkg::END_BAD;
        end
        else return pmcr_pkg::BYTE_IDLE;
        cstep++;
        return r;
    endfunction

    function automatic logic [7:0] card_reply(logic [7:0] tx);
        logic [7:0] r;
        int unsigned pos;
        case (cstep)
            8'd0:
            begin
                ccmd = tx;
                csum = 8'h00;
                cstep = 8'd1;
                return flag;
            end
            8'd1: begin cstep = 8'd2; return pmcr_pkg::BYTE_5A; end
            8'd2: begin cstep = 8'd3; return pmcr_pkg::BYTE_5D; end
            8'd3:
            begin
                sect = {tx, 8'h00};
                csum = tx;
                last_tx = tx;
                cstep = 8'd4;
                return 8'h00;
            end
            8'd4:
            begin
                sect[7:0] = tx;
                csum ^= tx;
                r = last_tx;
                last_tx = tx;
                cstep = 8'd5;
                return r;
            end
            default:
            begin
                if (cstep == pmcr_pkg::STEP_DONE) return pmcr_pkg::BYTE_IDLE;
                pos = cstep - 5;
                if (ccmd == pmcr_pkg::CARD_READ) return card_read_reply(pos);
                if (ccmd == pmcr_pkg::CARD_WRITE) return card_write_reply(pos, tx);
                if (ccmd == pmcr_pkg::CARD_GET_ID && pos < 6)
                begin
                    cstep = (pos == 5) ? pmcr_pkg::STEP_DONE : cstep + 8'd1;
                    return pmcr_pkg::id_reply(pos[2:0]);
                end
                return pmcr_pkg::BYTE_IDLE;
            end
        endcase
    endfunction

    // one exchange or deselect -> one reply
    function automatic reply_t exchange(xfer_t x);
        reply_t o;
        logic [2:0] prev;
        o.rx = pmcr_pkg::BYTE_IDLE;
        o.ack = 1'b0;
        if (x.op)
        begin
            sel_dev = pmcr_pkg::DEV_NONE;
            cstep = 8'd0;
            pstep = 3'd0;
        end
        else if (sel_dev == pmcr_pkg::DEV_PAD)
        begin
            prev = pstep;
            o.rx = pad_reply(x.tx, x.buttons);
            o.ack = (pstep != prev);
        end
        else if (sel_dev == pmcr_pkg::DEV_CARD)
        begin
            o.rx = card_reply(x.tx);
            o.ack = (cstep != pmcr_pkg::STEP_DONE);
        end
        else if (x.tx == pmcr_pkg::CMD_SELECT && card_on)
        begin
            sel_dev = pmcr_pkg::DEV_CARD;
            cstep = 8'd0;
            o.ack = 1'b1;
        end
        else if (pad_on)
        begin
            prev = pstep;
            o.rx = pad_reply(x.tx, x.buttons);
            o.ack = (pstep != prev);
            if (o.ack) sel_dev = pmcr_pkg::DEV_PAD;
        end
        if (!o.ack) sel_dev = pmcr_pkg::DEV_NONE;
        return o;
    endfunction

    // ---------------- stimulus helpers ----------------
    task automatic push_byte(logic [7:0] tx);
        xfer_t x;
        x.op = 1'b0;
        x.tx = tx;
        x.buttons = 16'($urandom);
        pending.push_back(x);
    endtask

    task automatic push_deselect();
        xfer_t x;
        x.op = 1'b1;
        x.tx = 8'($urandom);
        x.buttons = 16'($urandom);
        pending.push_back(x);
    endtask

    task automatic pad_poll(logic [15:0] b);
        xfer_t x;
        x.op = 1'b0;
        x.buttons = b;
        x.tx = pmcr_pkg::CMD_PAD_POLL;
        pending.push_back(x);
        for (int i = 0; i < 4; i++)
        begin
            x.tx = 8'($urandom);
            pending.push_back(x);
        end
        push_deselect();
    endtask

    // select, command, two filler bytes, sector address
    task automatic card_head(logic [7:0] cmd, logic [15:0] s);
        push_byte(pmcr_pkg::CMD_SELECT);
        push_byte(cmd);
        push_byte(8'($urandom));
        push_byte(8'($urandom));
        push_byte(s[15:8]);
        push_byte(s[7:0]);
    endtask

    // ack bytes, sector echo, data bytes, checksum, end byte and up to two bytes past the end
    task automatic card_read(logic [15:0] s);
        int n;
        n = pmcr_pkg::SECTOR_BYTES + 6 + $urandom_range(0, 2);
        card_head(pmcr_pkg::CARD_READ, s);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom));
        push_deselect();
    endtask

    task automatic card_write(logic [15:0] s, bit good_sum);
        logic [7:0] sum;
        logic [7:0] d;
        card_head(pmcr_pkg::CARD_WRITE, s);
        sum = s[15:8] ^ s[7:0];
        for (int i = 0; i < pmcr_pkg::SECTOR_BYTES; i++)
        begin
            d = 8'($urandom);
            sum ^= d;
            push_byte(d);
        end
        push_byte(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
        for (int i = 0; i < 3 + $urandom_range(0, 2); i++)
            push_byte(8'($urandom));
        push_deselect();
    endtask

    task automatic card_id_or_junk(logic [7:0] cmd);
        card_head(cmd, 16'($urandom));
        for (int i = 0; i < 6 + $urandom_range(0, 3); i++)
            push_byte(8'($urandom));
        push_deselect();
    endtask

    task automatic wait_drained();
        while (pending.size() != 0 || replies.size() != 0)
            @(posedge clk);
        // idle margin; a good write has already copied its buffer before its next byte was taken
        repeat (200) @(posedge clk);
    endtask

    task automatic write_cfg(logic [0:0] idx, logic val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == pmcr_pkg::REG_PAD_CONNECTED) pad_on = val;
        else card_on = val;
    endtask

    // ---------------- clock, reset, limit ----------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_pad_and_memory_card_responder_top: FAIL");
            $finish;
        end
    end

    // ---------------- driver ----------------
    int src_wait;
    int src_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            src_wait <= 0;
        end
        else if (s_tvalid && !s_tready)
        begin
            // hold the offered transfer
        end
        else if (s_tvalid && s_tready)
        begin
            // transfer taken: predict now, then draw the gap before the next one
            replies.push_back(exchange(pending.pop_front()));
            src_gap = $urandom_range(0, 5);
            if (src_gap == 0 && pending.size() != 0)
            begin
                s_tdata <= {pending[0].buttons, pending[0].tx};
                s_tuser <= pending[0].op;
            end
            else
            begin
                s_tvalid <= 1'b0;
                src_wait <= (src_gap == 0) ? 0 : src_gap - 1;
            end
        end
        else if (src_wait != 0)
            src_wait <= src_wait - 1;
        else if (pending.size() != 0)
        begin
            s_tvalid <= 1'b1;
            s_tdata <= {pending[0].buttons, pending[0].tx};
            s_tuser <= pending[0].op;
        end
    end

    // ---------------- monitor ----------------
    int dst_wait;
    int dst_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            dst_wait <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (replies.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected reply rx=%h ack=%b", m_tdata[7:0], m_tdata[8]);
            end
            else if (m_tdata[7:0] !== replies[0].rx || m_tdata[8] !== replies[0].ack)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("reply mismatch: exp rx=%h ack=%b got rx=%h ack=%b",
                             replies[0].rx, replies[0].ack, m_tdata[7:0], m_tdata[8]);
                void'(replies.pop_front());
            end
            else
                void'(replies.pop_front());
            // stall drawn per transfer: m_tready drops before the next one unless the draw is zero
            dst_gap = $urandom_range(0, 5);
            if (dst_gap != 0)
            begin
                m_tready <= 1'b0;
                dst_wait <= dst_gap - 1;
            end
        end
        else if (!m_tready)
        begin
            if (dst_wait == 0)
                m_tready <= 1'b1;
            else
                dst_wait <= dst_wait - 1;
        end
    end

    // ---------------- test sequence ----------------
    initial
    begin
        int k;
        n_bad = 0;
        cycles = 0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        for (int i = 0; i < CARD_SIZE; i++) mem_img[i] = 8'h00;
        for (int i = 0; i < pmcr_pkg::SECTOR_BYTES; i++) wbuf[i] = 8'h00;
        sel_dev = pmcr_pkg::DEV_NONE;
        pstep = 3'd0;
        cstep = 8'd0;
        ccmd = 8'h00;
        sect = 16'h0000;
        csum = 8'h00;
        last_tx = 8'h00;
        flag = pmcr_pkg::FLAG_RESET;
        wr_ok = 1'b0;
        pad_on = 1'b0;
        card_on = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // nobody attached: every byte answers idle
        push_byte(pmcr_pkg::CMD_SELECT);
        push_byte(pmcr_pkg::CMD_PAD_POLL);
        push_byte(8'h00);
        push_deselect();
        wait_drained();

        write_cfg(pmcr_pkg::REG_PAD_CONNECTED, 1'b1);
        write_cfg(pmcr_pkg::REG_CARD_PRESENT, 1'b1);
        // directed: pad extremes, wrong pad command, past last byte
        pad_poll(16'h0000);
        pad_poll(16'hFFFF);
        push_byte(8'h42);
        push_deselect();
        // card: get-ID, unknown command, out-of-range read, writes, read back
        card_id_or_junk(pmcr_pkg::CARD_GET_ID);
        card_id_or_junk(8'h00);
        card_read(16'hFFFF);
        card_write(16'h0003, 1'b1);
        card_write(16'h0003, 1'b0);
        card_write(16'(NSECT), 1'b1);
        card_read(16'h0003);
        wait_drained();

        // random phases: pad and card settings vary per phase, never both off
        for (int ph = 0; ph < 4; ph++)
        begin
            write_cfg(pmcr_pkg::REG_PAD_CONNECTED, ph[0]);
            write_cfg(pmcr_pkg::REG_CARD_PRESENT, ph[1] | (ph == 0));
            k = 0;
            while (k < 3)
            begin
                case ($urandom_range(0, 5))
                    0, 1: pad_poll(16'($urandom));
                    2: card_id_or_junk(pmcr_pkg::CARD_GET_ID);
                    3: card_id_or_junk(8'($urandom));
                    default:
                    begin
                        for (int i = 0; i < $urandom_range(1, 8); i++)
                            if ($urandom_range(0, 3) == 0) push_deselect();
                            else push_byte($urandom_range(0, 1) ? pmcr_pkg::CMD_SELECT
                                                                : 8'($urandom));
                    end
                endcase
                k++;
            end
            wait_drained();
        end

        if (n_bad == 0)
            $display("tb_pad_and_memory_card_responder_top: PASS");
        else
            $display("tb_pad_and_memory_card_responder_top: FAIL");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+sv
sv/pmcr_pkg.sv
sv/pmcr_ctrl.sv
sv/pmcr_dp.sv
sv/pad_and_memory_card_responder_top.sv
test/tb_pad_and_memory_card_responder_top.sv
